/* rtl/vfns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfns_pkg
// Shared types, field widths and register codes of the voxel field smoother.
// ----------------------------------------------------------------------------
package vfns_pkg;

	localparam int COMP_BITS = 24;
	typedef logic signed [COMP_BITS-1:0] comp_t;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd3;

	localparam int SZX_W    = 8;
	localparam int SZY_W    = 6;
	localparam int SZZ_W    = 6;
	localparam int LAMBDA_W = 16;

	localparam logic [SZX_W-1:0]    SIZE_X_RST = 8'd100;
	localparam logic [SZY_W-1:0]    SIZE_Y_RST = 6'd30;
	localparam logic [SZZ_W-1:0]    SIZE_Z_RST = 6'd30;
	localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 16'd16384;

	// request kinds
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_DRAIN  = 1'b1;

	// arithmetic widths
	localparam int NB_W    = 5;
	localparam int NB_MIN  = 7;
	localparam int NB_MAX  = 26;
	localparam int SUM_W   = COMP_BITS + NB_W;
	localparam int DIFF_W  = COMP_BITS + 6;
	localparam int PROD_W  = DIFF_W + LAMBDA_W + 1;
	localparam int FRAC    = 15;
	localparam int QUO_W   = PROD_W - FRAC;
	localparam int RES_W   = QUO_W + 2;
	localparam int QCNT_W  = $clog2(QUO_W);

	typedef struct packed {
		logic capture;
		logic store;
		logic scan_start;
		logic scan;
		logic diff;
		logic mul;
		logic prep;
		logic div;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic store_ok;
		logic emit_ok;
		logic scan_last;
		logic div_last;
		logic out_full;
	} dp_sts_t;

endpackage

/* rtl/vfns_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfns_in_if
// Request channel carrying voxel samples and drain ticks.
// ----------------------------------------------------------------------------
interface vfns_in_if;
	import vfns_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	comp_t comp_x;
	comp_t comp_y;
	comp_t comp_z;

	modport source (output valid, action, comp_x, comp_y, comp_z, input ready);
	modport sink   (input valid, action, comp_x, comp_y, comp_z, output ready);
endinterface

/* rtl/vfns_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfns_out_if
// Result channel carrying smoothed voxel vectors.
// ----------------------------------------------------------------------------
interface vfns_out_if;
	import vfns_pkg::*;

	logic  valid;
	logic  ready;
	comp_t smooth_x;
	comp_t smooth_y;
	comp_t smooth_z;
	logic  last_voxel;

	modport source (output valid, smooth_x, smooth_y, smooth_z, last_voxel, input ready);
	modport sink   (input valid, smooth_x, smooth_y, smooth_z, last_voxel, output ready);
endinterface

/* rtl/voxel_field_neighbour_smoothing_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_field_neighbour_smoothing_top
// 26-neighbour smoothing of a 3-component voxel field streamed in raster order.
// ----------------------------------------------------------------------------
// a request that yields no result passes only through the wait and decide states
// a request that yields a result is valid only after a window scan and a divide:
//   27 reads of the window ring through its one read port plus a 32-step serial divider
// a further request is taken while a finished result waits on the output
// reset (arst_n low) clears positions and config to 100 x 30 x 30, lambda one half;
//   the window ring is not cleared, every read entry is written in the same volume
module voxel_field_neighbour_smoothing_top #(
	parameter int MAX_X = 128,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vfns_in_if.sink                         in_ch,
	vfns_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [vfns_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [vfns_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import vfns_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	vfns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	vfns_dp #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_action    (in_ch.action),
		.in_comp_x    (in_ch.comp_x),
		.in_comp_y    (in_ch.comp_y),
		.in_comp_z    (in_ch.comp_z),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_smooth_x (out_ch.smooth_x),
		.out_smooth_y (out_ch.smooth_y),
		.out_smooth_z (out_ch.smooth_z),
		.out_last     (out_ch.last_voxel)
	);
endmodule

/* rtl/vfns_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfns_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module vfns_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 8451
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/vfns_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfns_ctrl
// Sequencer: accepts one request, then walks store and, when a result is due, window scan and divide.
// ----------------------------------------------------------------------------
module vfns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output vfns_pkg::dp_cmd_t cmd,
	input  vfns_pkg::dp_sts_t sts
);
	import vfns_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WAIT   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_SCAN   = 4'd3;
	localparam logic [3:0] S_TAIL   = 4'd4;
	localparam logic [3:0] S_DIFF   = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_PREP   = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nx = S_WAIT;
				end
			end
			// size products settle
			S_WAIT: state_nx = S_DECIDE;
			S_DECIDE: begin
				cmd.store = sts.store_ok;
				if (sts.emit_ok) begin
					cmd.scan_start = 1'b1;
					state_nx       = S_SCAN;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_nx = S_TAIL;
				end
			end
			S_TAIL: state_nx = S_DIFF;
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_nx = S_MUL;
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_nx = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_full) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_full)
		else $error("result loaded over a pending result");

	a_scan_after_store: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> cmd.scan && !cmd.store)
		else $error("window scan did not follow its start");
endmodule

/* rtl/vfns_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfns_dp
// Datapath: config registers, window ring memory, neighbour accumulate,
// blend multiply, serial divider and the result register.
// ----------------------------------------------------------------------------
module vfns_dp #(
	parameter int MAX_X = 128,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vfns_pkg::dp_cmd_t                   cmd,
	output vfns_pkg::dp_sts_t                   sts,
	input  logic                                cfg_we,
	input  logic [vfns_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [vfns_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_action,
	input  vfns_pkg::comp_t                     in_comp_x,
	input  vfns_pkg::comp_t                     in_comp_y,
	input  vfns_pkg::comp_t                     in_comp_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output vfns_pkg::comp_t                     out_smooth_x,
	output vfns_pkg::comp_t                     out_smooth_y,
	output vfns_pkg::comp_t                     out_smooth_z,
	output logic                                out_last
);
	import vfns_pkg::*;

	localparam int DEPTH = 2 * (MAX_X * MAX_Y + MAX_X + 1) + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = AW + 2;
	localparam int SXW   = $clog2(MAX_X + 1);
	localparam int SYW   = $clog2(MAX_Y + 1);
	localparam int SZW   = $clog2(MAX_Z + 1);
	localparam int XW    = $clog2(MAX_X);
	localparam int YW    = $clog2(MAX_Y);
	localparam int ZW    = $clog2(MAX_Z);
	localparam int PLW   = $clog2(MAX_X * MAX_Y + 1);
	localparam int LGW   = $clog2(MAX_X * MAX_Y + MAX_X + 2);
	localparam int VW    = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
	localparam int WW    = 3 * COMP_BITS;

	localparam logic signed [RES_W-1:0] SAT_HI =
		{{(RES_W-COMP_BITS+1){1'b0}}, {(COMP_BITS-1){1'b1}}};
	localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

	// configuration
	logic [SZX_W-1:0]    size_x_q;
	logic [SZY_W-1:0]    size_y_q;
	logic [SZZ_W-1:0]    size_z_q;
	logic [LAMBDA_W-1:0] lambda_q;
	logic                resize;

	assign resize = cfg_we && (cfg_idx == CFG_SIZE_X || cfg_idx == CFG_SIZE_Y ||
		cfg_idx == CFG_SIZE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_X_RST;
			size_y_q <= SIZE_Y_RST;
			size_z_q <= SIZE_Z_RST;
			lambda_q <= LAMBDA_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SIZE_X: size_x_q <= cfg_wdata[SZX_W-1:0];
				CFG_SIZE_Y: size_y_q <= cfg_wdata[SZY_W-1:0];
				CFG_SIZE_Z: size_z_q <= cfg_wdata[SZZ_W-1:0];
				CFG_LAMBDA: lambda_q <= cfg_wdata[LAMBDA_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SXW-1:0] sx_eff;
	logic [SYW-1:0] sy_eff;
	logic [SZW-1:0] sz_eff;

	always_comb begin
		if (size_x_q < SZX_W'(2))        sx_eff = SXW'(2);
		else if (int'(size_x_q) > MAX_X) sx_eff = SXW'(MAX_X);
		else                             sx_eff = SXW'(size_x_q);
		if (size_y_q < SZY_W'(2))        sy_eff = SYW'(2);
		else if (int'(size_y_q) > MAX_Y) sy_eff = SYW'(MAX_Y);
		else                             sy_eff = SYW'(size_y_q);
		if (size_z_q < SZZ_W'(2))        sz_eff = SZW'(2);
		else if (int'(size_z_q) > MAX_Z) sz_eff = SZW'(MAX_Z);
		else                             sz_eff = SZW'(size_z_q);
	end

	logic [PLW-1:0] plane_q;
	logic [LGW-1:0] lag_q;
	logic [VW-1:0]  vol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
			lag_q   <= '0;
			vol_q   <= '0;
		end else begin
			plane_q <= PLW'(sx_eff) * PLW'(sy_eff);
			lag_q   <= LGW'(plane_q) + LGW'(sx_eff) + LGW'(1);
			vol_q   <= VW'(plane_q) * VW'(sz_eff);
		end
	end

	// request capture
	logic  act_q;
	comp_t item_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_SAMPLE;
		end else if (cmd.capture) begin
			act_q <= in_action;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q[0] <= in_comp_x;
			item_q[1] <= in_comp_y;
			item_q[2] <= in_comp_z;
		end
	end

	// stream positions
	logic [VW-1:0] in_pos_q;
	logic [VW-1:0] out_pos_q;
	logic [AW-1:0] wr_addr_q;
	logic [AW-1:0] rd_base_q;
	logic [XW-1:0] ox_q;
	logic [YW-1:0] oy_q;
	logic [ZW-1:0] oz_q;
	logic          x_hi;
	logic          y_hi;
	logic          z_hi;
	logic          vol_done;

	assign x_hi     = (SXW'(ox_q) == sx_eff - SXW'(1));
	assign y_hi     = (SYW'(oy_q) == sy_eff - SYW'(1));
	assign z_hi     = (SZW'(oz_q) == sz_eff - SZW'(1));
	assign vol_done = (out_pos_q + VW'(1) >= vol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q  <= '0;
			out_pos_q <= '0;
			wr_addr_q <= '0;
			rd_base_q <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			oz_q      <= '0;
		end else if (resize || (cmd.load_out && act_q == ACT_DRAIN && vol_done)) begin
			in_pos_q  <= '0;
			out_pos_q <= '0;
			wr_addr_q <= '0;
			rd_base_q <= '0;
			ox_q      <= '0;
			oy_q      <= '0;
			oz_q      <= '0;
		end else begin
			if (cmd.store) begin
				in_pos_q  <= in_pos_q + VW'(1);
				wr_addr_q <= (wr_addr_q == AW'(DEPTH - 1)) ? '0 : wr_addr_q + AW'(1);
			end
			if (cmd.load_out) begin
				out_pos_q <= out_pos_q + VW'(1);
				rd_base_q <= (rd_base_q == AW'(DEPTH - 1)) ? '0 : rd_base_q + AW'(1);
				if (x_hi) begin
					ox_q <= '0;
					if (y_hi) begin
						oy_q <= '0;
						oz_q <= oz_q + ZW'(1);
					end else begin
						oy_q <= oy_q + YW'(1);
					end
				end else begin
					ox_q <= ox_q + XW'(1);
				end
			end
		end
	end

	logic drain_emit;
	assign drain_emit   = (act_q == ACT_DRAIN) && (in_pos_q >= vol_q) && (out_pos_q < vol_q);
	assign sts.store_ok = (act_q == ACT_SAMPLE) && (in_pos_q < vol_q);
	assign sts.emit_ok  = (act_q == ACT_SAMPLE) ? (sts.store_ok && in_pos_q >= VW'(lag_q))
		: drain_emit;

	// window scan over the 3x3x3 neighbourhood
	logic signed [1:0] dx_q, dy_q, dz_q;
	logic signed [SW-1:0] pz, py, ofs, asum, afix;
	logic [AW-1:0] raddr;
	logic          in_grid;
	logic          center;

	assign sts.scan_last = (dx_q == 2'sd1) && (dy_q == 2'sd1) && (dz_q == 2'sd1);

	always_comb begin
		pz   = $signed(SW'(plane_q));
		py   = $signed(SW'(sx_eff));
		ofs  = SW'(dx_q);
		if (dy_q == -2'sd1)     ofs = ofs - py;
		else if (dy_q == 2'sd1) ofs = ofs + py;
		if (dz_q == -2'sd1)     ofs = ofs - pz;
		else if (dz_q == 2'sd1) ofs = ofs + pz;
		asum = $signed(SW'(rd_base_q)) + ofs;
		if (asum < 0)                   afix = asum + SW'(DEPTH);
		else if (asum >= SW'(DEPTH))    afix = asum - SW'(DEPTH);
		else                            afix = asum;
		raddr = afix[AW-1:0];
		in_grid = !(dx_q == -2'sd1 && ox_q == '0) && !(dx_q == 2'sd1 && x_hi) &&
			!(dy_q == -2'sd1 && oy_q == '0) && !(dy_q == 2'sd1 && y_hi) &&
			!(dz_q == -2'sd1 && oz_q == '0) && !(dz_q == 2'sd1 && z_hi);
		center  = (dx_q == 2'sd0) && (dy_q == 2'sd0) && (dz_q == 2'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= -2'sd1;
			dy_q <= -2'sd1;
			dz_q <= -2'sd1;
		end else if (cmd.scan_start) begin
			dx_q <= -2'sd1;
			dy_q <= -2'sd1;
			dz_q <= -2'sd1;
		end else if (cmd.scan) begin
			if (dx_q == 2'sd1) begin
				dx_q <= -2'sd1;
				if (dy_q == 2'sd1) begin
					dy_q <= -2'sd1;
					dz_q <= dz_q + 2'sd1;
				end else begin
					dy_q <= dy_q + 2'sd1;
				end
			end else begin
				dx_q <= dx_q + 2'sd1;
			end
		end
	end

	logic [WW-1:0] rdata;

	vfns_ram #(
		.WIDTH (WW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (wr_addr_q),
		.wdata ({item_q[2], item_q[1], item_q[0]}),
		.raddr (raddr),
		.rdata (rdata)
	);

	logic rd_vld_s1;
	logic rd_ctr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_ctr_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan && in_grid && !center;
			rd_ctr_s1 <= cmd.scan && center;
		end
	end

	// per-lane arithmetic
	logic signed [SUM_W-1:0]  sum_q  [3];
	comp_t                    f_q    [3];
	logic [NB_W-1:0]          n_q;
	logic signed [DIFF_W-1:0] diff_q [3];
	logic signed [PROD_W-1:0] prod_q [3];
	logic                     neg_q  [3];
	logic [QUO_W-1:0]         quo_q  [3];
	logic [NB_W-1:0]          rem_q  [3];
	logic [QCNT_W-1:0]        cnt_q;

	logic [PROD_W-1:0]        mag    [3];
	logic [PROD_W-1:0]        rnd    [3];
	logic [NB_W:0]            trial  [3];
	logic                     ge     [3];
	logic [NB_W-1:0]          rem_nx [3];
	logic signed [RES_W-1:0]  res    [3];
	comp_t                    sat    [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag[c]    = prod_q[c][PROD_W-1] ? PROD_W'(-prod_q[c]) : PROD_W'(prod_q[c]);
			rnd[c]    = mag[c] + (PROD_W'(n_q) << (FRAC - 1));
			trial[c]  = {rem_q[c], quo_q[c][QUO_W-1]};
			ge[c]     = (trial[c] >= {1'b0, n_q});
			rem_nx[c] = ge[c] ? NB_W'(trial[c] - {1'b0, n_q}) : NB_W'(trial[c]);
			res[c]    = neg_q[c] ? RES_W'(f_q[c]) - $signed({2'b00, quo_q[c]})
				: RES_W'(f_q[c]) + $signed({2'b00, quo_q[c]});
			if (res[c] > SAT_HI)      sat[c] = SAT_HI[COMP_BITS-1:0];
			else if (res[c] < SAT_LO) sat[c] = SAT_LO[COMP_BITS-1:0];
			else                      sat[c] = res[c][COMP_BITS-1:0];
		end
	end

	assign sts.div_last = (cnt_q == QCNT_W'(QUO_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			n_q <= '0;
		end else if (rd_vld_s1) begin
			n_q <= n_q + NB_W'(1);
		end
		if (cmd.prep) begin
			cnt_q <= '0;
		end else if (cmd.div) begin
			cnt_q <= cnt_q + QCNT_W'(1);
		end
		for (int c = 0; c < 3; c++) begin
			if (cmd.scan_start) begin
				sum_q[c] <= '0;
			end else if (rd_vld_s1) begin
				sum_q[c] <= sum_q[c] + SUM_W'($signed(rdata[c*COMP_BITS +: COMP_BITS]));
			end
			if (rd_ctr_s1) begin
				f_q[c] <= $signed(rdata[c*COMP_BITS +: COMP_BITS]);
			end
			if (cmd.diff) begin
				diff_q[c] <= DIFF_W'(sum_q[c]) - DIFF_W'(f_q[c]) * $signed({1'b0, n_q});
			end
			if (cmd.mul) begin
				prod_q[c] <= PROD_W'(diff_q[c]) * PROD_W'($signed({1'b0, lambda_q}));
			end
			if (cmd.prep) begin
				neg_q[c] <= prod_q[c][PROD_W-1];
				quo_q[c] <= rnd[c][PROD_W-1:FRAC];
				rem_q[c] <= '0;
			end else if (cmd.div) begin
				quo_q[c] <= {quo_q[c][QUO_W-2:0], ge[c]};
				rem_q[c] <= rem_nx[c];
			end
		end
	end

	// result register
	logic out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_smooth_x <= sat[0];
			out_smooth_y <= sat[1];
			out_smooth_z <= sat[2];
			out_last     <= (out_pos_q == vol_q - VW'(1));
		end
	end

	assign out_valid    = out_full_q;
	assign sts.out_full = out_full_q;

	a_out_behind_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_pos_q <= in_pos_q)
		else $error("result position passed input position");

	a_in_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_pos_q <= vol_q)
		else $error("input position beyond volume");

	a_neighbour_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |-> (n_q >= NB_W'(NB_MIN) && n_q <= NB_W'(NB_MAX)))
		else $error("neighbour count out of range");
endmodule

/* tb/sv/tb_voxel_field_neighbour_smoothing_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_field_neighbour_smoothing_top
// Streams voxel volumes of many sizes and blend weights through the smoother,
// one of them abandoned part way, and checks every smoothed vector against a
// software smoother kept in step with the accepted requests.
// ----------------------------------------------------------------------------
module tb_voxel_field_neighbour_smoothing_top;
	import vfns_pkg::*;

	localparam int VOX_MAX = 128 * 32 * 32;

	typedef struct {
		comp_t x;
		comp_t y;
		comp_t z;
		logic  last;
	} smooth_vec_t;

	class smoothing_scoreboard;
		logic [SZX_W-1:0]    size_x;
		logic [SZY_W-1:0]    size_y;
		logic [SZZ_W-1:0]    size_z;
		logic [LAMBDA_W-1:0] lambda;
		int unsigned in_pos;
		int unsigned out_pos;
		comp_t voxels[VOX_MAX][3];
		smooth_vec_t pending[$];
		int errors;
		int checked;

		function new();
			size_x  = SIZE_X_RST;
			size_y  = SIZE_Y_RST;
			size_z  = SIZE_Z_RST;
			lambda  = LAMBDA_RST;
			in_pos  = 0;
			out_pos = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function int unsigned clamp_extent(int unsigned v, int unsigned hi);
			if (v < 2) return 2;
			if (v > hi) return hi;
			return v;
		endfunction

		function int unsigned ext_x();
			return clamp_extent(size_x, 128);
		endfunction

		function int unsigned ext_y();
			return clamp_extent(size_y, 32);
		endfunction

		function int unsigned ext_z();
			return clamp_extent(size_z, 32);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_SIZE_X: begin
					size_x = d[SZX_W-1:0]; in_pos = 0; out_pos = 0;
				end
				CFG_SIZE_Y: begin
					size_y = d[SZY_W-1:0]; in_pos = 0; out_pos = 0;
				end
				CFG_SIZE_Z: begin
					size_z = d[SZZ_W-1:0]; in_pos = 0; out_pos = 0;
				end
				CFG_LAMBDA: lambda = d;
				default: ;
			endcase
		endfunction

		// blended and saturated vector of voxel p
		function smooth_vec_t smooth_voxel(int unsigned p);
			smooth_vec_t v;
			int unsigned sx, sy, sz, vol;
			int px, py, pz, nx, ny, nz;
			longint sum[3];
			longint n, f, num, den, mag, q, r;
			comp_t res[3];
			sx = ext_x(); sy = ext_y(); sz = ext_z();
			vol = sx * sy * sz;
			px = p % sx; py = (p / sx) % sy; pz = p / (sx * sy);
			sum[0] = 0; sum[1] = 0; sum[2] = 0;
			n = 0;
			for (int dz = -1; dz <= 1; dz++)
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++) begin
						nx = px + dx; ny = py + dy; nz = pz + dz;
						if (dx == 0 && dy == 0 && dz == 0) continue;
						if (nx < 0 || ny < 0 || nz < 0) continue;
						if (nx >= int'(sx) || ny >= int'(sy) || nz >= int'(sz)) continue;
						for (int c = 0; c < 3; c++)
							sum[c] += voxels[(nz * sy + ny) * sx + nx][c];
						n++;
					end
			for (int c = 0; c < 3; c++) begin
				f   = voxels[p][c];
				num = longint'(lambda) * (sum[c] - n * f);
				den = n * 32768;
				mag = num < 0 ? -num : num;
				q   = (mag + den / 2) / den;
				r   = f + (num < 0 ? -q : q);
				if (r > 64'sd8388607) r = 64'sd8388607;
				if (r < -64'sd8388608) r = -64'sd8388608;
				res[c] = comp_t'(r);
			end
			v.x = res[0]; v.y = res[1]; v.z = res[2];
			v.last = (p == vol - 1);
			return v;
		endfunction

		function void note_request(logic act, comp_t cx, comp_t cy, comp_t cz);
			int unsigned sx, sy, vol, lag;
			sx  = ext_x(); sy = ext_y();
			vol = sx * sy * ext_z();
			lag = sx * sy + sx + 1;
			if (act == ACT_SAMPLE) begin
				if (in_pos >= vol) return;
				voxels[in_pos][0] = cx;
				voxels[in_pos][1] = cy;
				voxels[in_pos][2] = cz;
				if (in_pos >= lag) begin
					pending.insert(pending.size(), smooth_voxel(out_pos));
					out_pos++;
				end
				in_pos++;
			end else begin
				if (in_pos < vol || out_pos >= vol) return;
				pending.insert(pending.size(), smooth_voxel(out_pos));
				out_pos++;
				if (out_pos >= vol) begin
					in_pos  = 0;
					out_pos = 0;
				end
			end
		endfunction

		task report(string msg);
			$display("tb: mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(smooth_vec_t got);
			smooth_vec_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.x !== want.x)
				report($sformatf("smooth_x got %0d want %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("smooth_y got %0d want %0d", got.y, want.y));
			if (got.z !== want.z)
				report($sformatf("smooth_z got %0d want %0d", got.z, want.z));
			if (got.last !== want.last)
				report($sformatf("last_voxel got %0b want %0b", got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	vfns_in_if  in_ch();
	vfns_out_if out_ch();

	voxel_field_neighbour_smoothing_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	smoothing_scoreboard smoother = new();

	int  requests_sent = 0;
	int  volumes_done  = 0;
	bit  no_idle       = 0;
	bit  hold_req      = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#(20 * 3000000);
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && in_ch.valid && in_ch.ready)
			smoother.note_request(in_ch.action, in_ch.comp_x, in_ch.comp_y, in_ch.comp_z);

	always @(posedge clk) begin
		smooth_vec_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.x = out_ch.smooth_x;
			got.y = out_ch.smooth_y;
			got.z = out_ch.smooth_z;
			got.last = out_ch.last_voxel;
			smoother.check_result(got);
		end
	end

	function int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	function comp_t pick_comp(bit extremes);
		int r;
		r = $urandom_range(0, extremes ? 3 : 9);
		case (r)
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'sh000000;
			3: return 24'shFFFFFF;
			default: return comp_t'($urandom);
		endcase
	endfunction

	task send(logic act, comp_t cx, comp_t cy, comp_t cz);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.action <= act;
		in_ch.comp_x <= cx;
		in_ch.comp_y <= cy;
		in_ch.comp_z <= cz;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (smoother.pending.size() != 0) @(posedge clk);
		// a request that gives no result may still be in flight
		repeat (100) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		smoother.write_reg(idx, d);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one volume; abandon_at >= 0 stops feeding there and moves on
	task run_volume(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz, logic [15:0] lam,
			bit extremes, int abandon_at, bit lambda_mid, bit pressure);
		int unsigned vol, lag;
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
		write_reg(CFG_LAMBDA, lam);
		vol = smoother.ext_x() * smoother.ext_y() * smoother.ext_z();
		lag = smoother.ext_x() * smoother.ext_y() + smoother.ext_x() + 1;
		no_idle = ($urandom_range(0, 3) == 0);
		for (int p = 0; p < vol; p++) begin
			if ($urandom_range(0, 24) == 0)
				send(ACT_DRAIN, comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
			send(ACT_SAMPLE, pick_comp(extremes), pick_comp(extremes), pick_comp(extremes));
			requests_sent++;
			if (pressure && p == lag + 4)
				hold_req = 1;
			if (p == abandon_at) begin
				wait_idle();
				no_idle = 0;
				return;
			end
			if (lambda_mid && p == vol / 2) begin
				wait_idle();
				write_reg(CFG_LAMBDA, 16'($urandom));
			end
		end
		for (int d = 0; d < lag; d++) begin
			if ($urandom_range(0, 24) == 0)
				send(ACT_SAMPLE, pick_comp(0), pick_comp(0), pick_comp(0));
			send(ACT_DRAIN, comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
			requests_sent++;
		end
		wait_idle();
		no_idle = 0;
		volumes_done++;
	endtask

	initial begin
		logic [15:0] lam;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = CFG_SIZE_X;
		cfg_wdata    = '0;
		in_ch.valid  = 1'b0;
		in_ch.action = ACT_SAMPLE;
		in_ch.comp_x = '0;
		in_ch.comp_y = '0;
		in_ch.comp_z = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: smallest volume at full, zero and above-one weight
		run_volume(16'd2, 16'd2, 16'd2, 16'd32768, 1, -1, 0, 0);
		run_volume(16'd0, 16'd1, 16'd2, 16'd0, 1, -1, 0, 0);
		run_volume(16'd2, 16'd2, 16'd2, 16'hFFFF, 1, -1, 0, 0);
		// abandoned volume, then weight change in the middle of one
		run_volume(16'd3, 16'd3, 16'd3, 16'd20000, 0, 10, 0, 0);
		run_volume(16'd3, 16'd2, 16'd3, 16'd12000, 0, -1, 1, 0);
		// largest extents, out of range values clamp
		run_volume(16'hFFFF, 16'd0, 16'd1, 16'($urandom), 0, -1, 0, 1);
		run_volume(16'd2, 16'hFF3F, 16'd2, 16'($urandom), 0, -1, 0, 0);
		run_volume(16'd2, 16'd2, 16'h1C20, 16'($urandom), 0, -1, 0, 0);

		while (requests_sent < 1150) begin
			case ($urandom_range(0, 3))
				0: lam = 16'($urandom_range(0, 32768));
				1: lam = 16'($urandom);
				2: lam = 16'd32768;
				default: lam = 16'($urandom_range(0, 8));
			endcase
			run_volume({8'($urandom), 8'($urandom_range(2, 6))},
				{10'($urandom), 6'($urandom_range(2, 4))},
				{10'($urandom), 6'($urandom_range(2, 3))},
				lam, $urandom_range(0, 3) == 0, -1, $urandom_range(0, 5) == 0, 0);
		end

		wait_idle();
		$display("tb: %0d requests over %0d complete volumes, %0d smoothed vectors checked",
			requests_sent, volumes_done, smoother.checked);
		if (smoother.errors == 0 && smoother.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
